/* src/acd_pkg.sv */
// Shared types, constants and pulse decode functions for the algebraic
// codebook pulse decoder. No dependencies.
package acd_pkg;

  localparam int unsigned VECTOR_LENGTH = 64;
  localparam int unsigned POS_W         = $clog2(VECTOR_LENGTH);
  localparam int unsigned CODE_W        = 7;
  localparam int unsigned WORD_W        = 14;
  localparam int unsigned NUM_WORDS     = 8;
  localparam int unsigned NUM_TRACKS    = 4;
  localparam int unsigned SLOTS_PER_TRK = 4;
  localparam int unsigned NUM_PULSES    = NUM_TRACKS * SLOTS_PER_TRK;
  localparam int unsigned PCNT_W        = $clog2(NUM_PULSES);
  localparam int unsigned VALUE_W       = 4;

  // Bit budgets that are decoded
  localparam logic [CODE_W-1:0] MODE_12 = 7'd12;
  localparam logic [CODE_W-1:0] MODE_16 = 7'd16;
  localparam logic [CODE_W-1:0] MODE_20 = 7'd20;
  localparam logic [CODE_W-1:0] MODE_28 = 7'd28;
  localparam logic [CODE_W-1:0] MODE_36 = 7'd36;
  localparam logic [CODE_W-1:0] MODE_44 = 7'd44;
  localparam logic [CODE_W-1:0] MODE_52 = 7'd52;
  localparam logic [CODE_W-1:0] MODE_64 = 7'd64;

  // Split codes of the four-pulse track word
  localparam logic [1:0] SPLIT_ONE_HALF = 2'd0;
  localparam logic [1:0] SPLIT_1_3      = 2'd1;
  localparam logic [1:0] SPLIT_2_2      = 2'd2;
  localparam logic [1:0] SPLIT_3_1      = 2'd3;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] index_words_t;

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic [POS_W-1:0] addr;
  } pulse_t;

  typedef pulse_t [1:0]               pulse_pair_t;
  typedef pulse_t [2:0]               pulse_triple_t;
  typedef pulse_t [SLOTS_PER_TRK-1:0] track_pulses_t;
  typedef pulse_t [NUM_PULSES-1:0]    pulse_list_t;

  // Control handed from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic acc_en;
    logic shift_en;
  } cell_ctrl_t;

  // Sample address = 4*pos + track, wrapping over the vector
  function automatic pulse_t put_pulse(logic [4:0] pos, logic [POS_W-1:0] track,
                                       logic neg);
    pulse_t p;
    p.vld  = 1'b1;
    p.neg  = neg;
    p.addr = {pos[3:0], 2'b00} + track;
    return p;
  endfunction

  function automatic pulse_t one_pulse(logic [15:0] word, int unsigned m,
                                       logic [4:0] base, logic [POS_W-1:0] track);
    logic [15:0] mask;
    logic [4:0]  pos;
    mask = 16'((32'd1 << m) - 32'd1);
    pos  = 5'(word & mask) + base;
    return put_pulse(pos, track, word[m]);
  endfunction

  // Second pulse flips sign when its position is below the first
  function automatic pulse_pair_t two_pulses(logic [15:0] word, int unsigned m,
                                             logic [4:0] base,
                                             logic [POS_W-1:0] track);
    logic [15:0] mask;
    logic [4:0]  first;
    logic [4:0]  second;
    logic        neg;
    pulse_pair_t pr;
    mask   = 16'((32'd1 << m) - 32'd1);
    first  = 5'((word >> m) & mask) + base;
    second = 5'(word & mask) + base;
    neg    = word[2*m];
    pr[0]  = put_pulse(first, track, neg);
    pr[1]  = put_pulse(second, track, (second < first) ? !neg : neg);
    return pr;
  endfunction

  function automatic pulse_triple_t three_pulses(logic [15:0] word, int unsigned m,
                                                 logic [4:0] base,
                                                 logic [POS_W-1:0] track);
    logic [15:0]   low_mask;
    logic [15:0]   hi_mask;
    logic [4:0]    half;
    pulse_pair_t   pr;
    pulse_triple_t tr;
    low_mask = 16'((32'd1 << (2*m - 1)) - 32'd1);
    hi_mask  = 16'((32'd1 << (m + 1)) - 32'd1);
    half     = base + (word[2*m-1] ? 5'(32'd1 << (m - 1)) : 5'd0);
    pr       = two_pulses(word & low_mask, m - 1, half, track);
    tr[1:0]  = pr;
    tr[2]    = one_pulse((word >> (2*m)) & hi_mask, m, base, track);
    return tr;
  endfunction

  function automatic track_pulses_t four_in_half(logic [15:0] word, logic [4:0] base,
                                                 logic [POS_W-1:0] track);
    logic [4:0]    quarter;
    track_pulses_t tp;
    quarter = base + (word[5] ? 5'd4 : 5'd0);
    tp[1:0] = two_pulses(word & 16'd31, 2, quarter, track);
    tp[3:2] = two_pulses((word >> 6) & 16'd127, 3, base, track);
    return tp;
  endfunction

  function automatic track_pulses_t four_pulses(logic [15:0] word,
                                                logic [POS_W-1:0] track);
    track_pulses_t tp;
    case (word[15:14])
      SPLIT_ONE_HALF: tp = four_in_half(word, word[13] ? 5'd8 : 5'd0, track);
      SPLIT_1_3: begin
        tp[0]   = one_pulse(word >> 10, 3, 5'd0, track);
        tp[3:1] = three_pulses(word, 3, 5'd8, track);
      end
      SPLIT_2_2: begin
        tp[1:0] = two_pulses(word >> 7, 3, 5'd0, track);
        tp[3:2] = two_pulses(word, 3, 5'd8, track);
      end
      default: begin
        tp[2:0] = three_pulses(word >> 4, 3, 5'd0, track);
        tp[3]   = one_pulse(word, 3, 5'd8, track);
      end
    endcase
    return tp;
  endfunction

  // Five-bit pulse: 4-bit position, sign on bit 4
  function automatic pulse_t five_bit_pulse(logic [WORD_W-1:0] word,
                                            logic [POS_W-1:0] track);
    return put_pulse({1'b0, word[3:0]}, track, word[4]);
  endfunction

  // Full pulse list of one subframe; in modes 20 to 64, slots 4t..4t+3 belong to track t
  function automatic pulse_list_t decode_pulses(logic [CODE_W-1:0] bits,
                                                index_words_t w);
    pulse_list_t       pl;
    logic [15:0]       wd;
    logic [POS_W-1:0]  trk;
    pl = '0;
    unique case (bits)
      MODE_12: begin
        pl[0] = five_bit_pulse(w[1], {w[0][4:0], 1'b0});
        pl[1] = five_bit_pulse(w[3], {w[2][4:0], 1'b1});
      end
      MODE_16: begin
        pl[0] = five_bit_pulse(w[1], POS_W'(0));
        if (w[0] == '0) begin
          pl[4] = five_bit_pulse(w[2], POS_W'(2));
          pl[8] = five_bit_pulse(w[3], POS_W'(3));
        end else begin
          pl[4] = five_bit_pulse(w[2], POS_W'(1));
          pl[8] = five_bit_pulse(w[3], POS_W'(2));
        end
      end
      MODE_20, MODE_28, MODE_36, MODE_44, MODE_52, MODE_64: begin
        for (int t = 0; t < NUM_TRACKS; t++) begin
          trk = POS_W'(t);
          wd  = {2'b00, w[t]};
          if (bits == MODE_20 || (bits == MODE_28 && t >= 2)) begin
            pl[4*t] = one_pulse(wd, 4, 5'd0, trk);
          end else if (bits == MODE_36 || bits == MODE_28 ||
                       (bits == MODE_44 && t >= 2)) begin
            pl[4*t +: 2] = two_pulses(wd, 4, 5'd0, trk);
          end else if (bits == MODE_44 || bits == MODE_52) begin
            pl[4*t +: 3] = three_pulses(wd, 4, 5'd0, trk);
          end else begin
            pl[4*t +: 4] = four_pulses({w[t][1:0], w[t+4]}, trk);
          end
        end
      end
      default: pl = '0;
    endcase
    return pl;
  endfunction

endpackage

/* src/acd_in_if.sv */
// Input channel: one subframe's bit budget and codebook index words.
// Depends on acd_pkg for field widths.
interface acd_in_if;
  logic                                valid;
  logic                                ready;
  logic [acd_pkg::CODE_W-1:0]          bit_budget;
  logic [acd_pkg::WORD_W-1:0]          pulse_index_0;
  logic [acd_pkg::WORD_W-1:0]          pulse_index_1;
  logic [acd_pkg::WORD_W-1:0]          pulse_index_2;
  logic [acd_pkg::WORD_W-1:0]          pulse_index_3;
  logic [acd_pkg::WORD_W-1:0]          pulse_index_4;
  logic [acd_pkg::WORD_W-1:0]          pulse_index_5;
  logic [acd_pkg::WORD_W-1:0]          pulse_index_6;
  logic [acd_pkg::WORD_W-1:0]          pulse_index_7;

  modport source (output valid, bit_budget, pulse_index_0, pulse_index_1, pulse_index_2,
                  pulse_index_3, pulse_index_4, pulse_index_5, pulse_index_6,
                  pulse_index_7, input ready);
  modport sink   (input valid, bit_budget, pulse_index_0, pulse_index_1, pulse_index_2,
                  pulse_index_3, pulse_index_4, pulse_index_5, pulse_index_6,
                  pulse_index_7, output ready);
endinterface

/* src/acd_out_if.sv */
// Result channel: one pulse vector sample per transaction.
// Depends on acd_pkg for field widths.
interface acd_out_if;
  logic                                valid;
  logic                                ready;
  logic [acd_pkg::POS_W-1:0]           sample_position;
  logic signed [acd_pkg::VALUE_W-1:0]  pulse_value;
  logic                                last_sample;

  modport source (output valid, sample_position, pulse_value, last_sample, input ready);
  modport sink   (input valid, sample_position, pulse_value, last_sample, output ready);
endinterface

/* src/acd_pulse_queue.sv */
// Decodes the index words into a list of signed pulses and hands them out
// one per cycle while step is high. Depends on acd_pkg.
module acd_pulse_queue (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [acd_pkg::CODE_W-1:0]    bit_budget,
  input  acd_pkg::index_words_t         words,
  output acd_pkg::pulse_t               head
);
  import acd_pkg::*;

  pulse_list_t list_r;
  pulse_list_t list_nxt;

  // Load the decoded list, then shift toward slot 0
  always_comb begin
    list_nxt = list_r;
    if (load) begin
      list_nxt = decode_pulses(bit_budget, words);
    end else if (step) begin
      list_nxt = {pulse_t'('0), list_r[NUM_PULSES-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    list_r <= list_nxt;
  end

  assign head = list_r[0];

endmodule

/* src/acd_cell.sv */
// One sample of the pulse vector: sums pulses aimed at its address and
// passes its value to the lower neighbor while draining. Depends on acd_pkg.
module acd_cell (
  input  logic                               clk,
  input  acd_pkg::cell_ctrl_t                ctrl,
  input  logic [acd_pkg::POS_W-1:0]          cell_idx,
  input  acd_pkg::pulse_t                    pulse,
  input  logic signed [acd_pkg::VALUE_W-1:0] nbr_val,
  output logic signed [acd_pkg::VALUE_W-1:0] val
);
  import acd_pkg::*;

  logic signed [VALUE_W-1:0] val_r;
  logic signed [VALUE_W-1:0] val_nxt;

  // Clear, accumulate a matching pulse, or take the neighbor's value
  always_comb begin
    val_nxt = val_r;
    if (ctrl.clear) begin
      val_nxt = '0;
    end else if (ctrl.acc_en && pulse.vld && pulse.addr == cell_idx) begin
      val_nxt = pulse.neg ? val_r - VALUE_W'(1) : val_r + VALUE_W'(1);
    end else if (ctrl.shift_en) begin
      val_nxt = nbr_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

/* src/algebraic_codebook_pulse_decoder_top.sv */
// Top level of the algebraic codebook pulse decoder: sequencer, pulse queue,
// a chain of sample cells and the output register. Depends on acd_pkg,
// acd_in_if, acd_out_if, acd_pulse_queue and acd_cell.
//
//  channel | dir | transaction carries
//  --------+-----+----------------------------------------------------------
//  in_ch   | in  | bit_budget, pulse_index_0..7 (one subframe)
//  out_ch  | out | sample_position, pulse_value, last_sample (64 per subframe)
//
// After acceptance the 16-entry pulse queue is applied to the cell chain one
// pulse per cycle, then the chain shifts one sample a cycle into the output
// register whenever the output register is free or out_ch.ready takes its sample.
// Reset clears the sequencer and the output valid; cells clear on acceptance.
// out_ch.ready low freezes the chain; in_ch.ready is high only when idle, and
// a new subframe may enter while the final sample still waits at the output.
module algebraic_codebook_pulse_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  acd_in_if.sink     in_ch,
  acd_out_if.source  out_ch
);
  import acd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DRAIN
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [PCNT_W-1:0]         pcnt_r;
  logic [PCNT_W-1:0]         pcnt_nxt;
  logic [POS_W-1:0]          pos_r;
  logic [POS_W-1:0]          pos_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [POS_W-1:0]          out_pos_r;
  logic [POS_W-1:0]          out_pos_nxt;
  logic signed [VALUE_W-1:0] out_value_r;
  logic signed [VALUE_W-1:0] out_value_nxt;
  logic                      out_last_r;
  logic                      out_last_nxt;

  logic                      in_fire;
  logic                      out_load;
  cell_ctrl_t                ctrl;
  pulse_t                    head;
  index_words_t              words;
  logic signed [VALUE_W-1:0] chain [VECTOR_LENGTH+1];

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_DRAIN) && (!out_valid_r || out_ch.ready);

  assign words[0] = in_ch.pulse_index_0;
  assign words[1] = in_ch.pulse_index_1;
  assign words[2] = in_ch.pulse_index_2;
  assign words[3] = in_ch.pulse_index_3;
  assign words[4] = in_ch.pulse_index_4;
  assign words[5] = in_ch.pulse_index_5;
  assign words[6] = in_ch.pulse_index_6;
  assign words[7] = in_ch.pulse_index_7;

  // Cell control
  assign ctrl.clear    = in_fire;
  assign ctrl.acc_en   = (state_r == ST_ACCUM);
  assign ctrl.shift_en = out_load;

  acd_pulse_queue u_queue (
    .clk        (clk),
    .load       (in_fire),
    .step       (ctrl.acc_en),
    .bit_budget (in_ch.bit_budget),
    .words      (words),
    .head       (head)
  );

  // Cell chain; the top cell is fed zero while draining
  assign chain[VECTOR_LENGTH] = '0;
  for (genvar k = 0; k < VECTOR_LENGTH; k++) begin : g_cell
    acd_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .cell_idx (POS_W'(k)),
      .pulse    (head),
      .nbr_val  (chain[k+1]),
      .val      (chain[k])
    );
  end

  // Sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    pcnt_nxt      = pcnt_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_ACCUM;
          pcnt_nxt  = '0;
        end
      end
      ST_ACCUM: begin
        pcnt_nxt = pcnt_r + PCNT_W'(1);
        if (pcnt_r == PCNT_W'(NUM_PULSES - 1)) begin
          state_nxt = ST_DRAIN;
          pos_nxt   = '0;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_value_nxt = chain[0];
          out_last_nxt  = (pos_r == POS_W'(VECTOR_LENGTH - 1));
          pos_nxt       = pos_r + POS_W'(1);
          if (pos_r == POS_W'(VECTOR_LENGTH - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pcnt_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pcnt_r      <= pcnt_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_pos_r   <= out_pos_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.sample_position = out_pos_r;
  assign out_ch.pulse_value     = out_value_r;
  assign out_ch.last_sample     = out_last_r;

  // Checks
  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_pos_r == POS_W'(VECTOR_LENGTH - 1))
    else $error("last sample flagged at wrong position");

  a_accept_starts_accum: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_ACCUM && pcnt_r == '0)
    else $error("accepted subframe did not start accumulation");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_value_r >= -4 && out_value_r <= 4)
    else $error("pulse sum out of range");

  a_drain_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && $past(out_load) && $past(state_r) == ST_DRAIN
    |-> pos_r == $past(pos_r) + POS_W'(1))
    else $error("sample positions not consecutive");

endmodule

/* tb/pulse_vector_checker.sv */
// Checker for the algebraic codebook pulse decoder: predicts the 64-sample
// pulse vector of every accepted subframe and compares the sample stream.
// Depends on acd_pkg, acd_in_if and acd_out_if.
module pulse_vector_checker (
  input  logic      clk,
  input  logic      rst_n,
  acd_in_if         in_ch,
  acd_out_if        out_ch,
  output int        mismatch_count,
  output int        pending_samples
);
  timeunit 1ns;
  timeprecision 1ps;
  import acd_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } sample_t;

  // Predicted samples, oldest first
  sample_t expected_samples [$];

  // Working copy of the pulse vector
  int pulse_sum [VECTOR_LENGTH];

  // Sample address = 4*pos + track, modulo the vector length
  function automatic void place_pulse(int unsigned pos, int unsigned track, bit negative);
    int unsigned addr;
    addr = ((pos << 2) + track) & (VECTOR_LENGTH - 1);
    pulse_sum[addr] = pulse_sum[addr] + (negative ? -1 : 1);
  endfunction

  function automatic void single_pulse(int unsigned word, int unsigned m,
                                       int unsigned base, int unsigned track);
    int unsigned mask;
    mask = (1 << m) - 1;
    place_pulse((word & mask) + base, track, ((word >> m) & 1) != 0);
  endfunction

  // Second pulse takes the opposite sign when it sits below the first
  function automatic void pulse_pair(int unsigned word, int unsigned m,
                                     int unsigned base, int unsigned track);
    int unsigned mask;
    int unsigned first;
    int unsigned second;
    bit          neg;
    mask   = (1 << m) - 1;
    first  = ((word >> m) & mask) + base;
    second = (word & mask) + base;
    neg    = ((word >> (2 * m)) & 1) != 0;
    place_pulse(first, track, neg);
    place_pulse(second, track, (second < first) ? !neg : neg);
  endfunction

  // Pair in the half chosen by bit 2m-1, plus one full-range pulse
  function automatic void pulse_triple(int unsigned word, int unsigned m,
                                       int unsigned base, int unsigned track);
    int unsigned low_mask;
    int unsigned half;
    low_mask = (1 << (2 * m - 1)) - 1;
    half     = base;
    if (((word >> (2 * m - 1)) & 1) != 0)
      half = half + (1 << (m - 1));
    pulse_pair(word & low_mask, m - 1, half, track);
    single_pulse((word >> (2 * m)) & ((1 << (m + 1)) - 1), m, base, track);
  endfunction

  function automatic void quad_in_half(int unsigned word, int unsigned base,
                                       int unsigned track);
    int unsigned quarter;
    quarter = base;
    if (((word >> 5) & 1) != 0)
      quarter = quarter + 4;
    pulse_pair(word & 31, 2, quarter, track);
    pulse_pair((word >> 6) & 127, 3, base, track);
  endfunction

  function automatic void quad_pulses(int unsigned word, int unsigned track);
    logic [1:0] split;
    split = 2'(word >> 14);
    case (split)
      SPLIT_ONE_HALF: quad_in_half(word, (((word >> 13) & 1) != 0) ? 8 : 0, track);
      SPLIT_1_3: begin
        single_pulse(word >> 10, 3, 0, track);
        pulse_triple(word, 3, 8, track);
      end
      SPLIT_2_2: begin
        pulse_pair(word >> 7, 3, 0, track);
        pulse_pair(word, 3, 8, track);
      end
      default: begin
        pulse_triple(word >> 4, 3, 0, track);
        single_pulse(word, 3, 8, track);
      end
    endcase
  endfunction

  // 4-bit position, sign on bit 4
  function automatic void sign_mag_pulse(int unsigned word, int unsigned track);
    place_pulse(word & 15, track, ((word >> 4) & 1) != 0);
  endfunction

  // Rebuild pulse_sum for one subframe
  function automatic void build_pulse_vector(logic [CODE_W-1:0] bits, index_words_t w);
    int unsigned wd [NUM_WORDS];
    int unsigned skip;
    int unsigned next;
    for (int i = 0; i < NUM_WORDS; i++)
      wd[i] = int'(w[i]);
    for (int k = 0; k < VECTOR_LENGTH; k++)
      pulse_sum[k] = 0;
    case (bits)
      MODE_12: begin
        sign_mag_pulse(wd[1], 2 * wd[0]);
        sign_mag_pulse(wd[3], 2 * wd[2] + 1);
      end
      MODE_16: begin
        skip = (wd[0] == 0) ? 1 : 3;
        next = 1;
        for (int t = 0; t < NUM_TRACKS; t++) begin
          if (t != skip) begin
            sign_mag_pulse(wd[next], t);
            next++;
          end
        end
      end
      MODE_20: for (int t = 0; t < NUM_TRACKS; t++) single_pulse(wd[t], 4, 0, t);
      MODE_28: begin
        for (int t = 0; t < NUM_TRACKS; t++) begin
          if (t < 2) pulse_pair(wd[t], 4, 0, t);
          else single_pulse(wd[t], 4, 0, t);
        end
      end
      MODE_36: for (int t = 0; t < NUM_TRACKS; t++) pulse_pair(wd[t], 4, 0, t);
      MODE_44: begin
        for (int t = 0; t < NUM_TRACKS; t++) begin
          if (t < 2) pulse_triple(wd[t], 4, 0, t);
          else pulse_pair(wd[t], 4, 0, t);
        end
      end
      MODE_52: for (int t = 0; t < NUM_TRACKS; t++) pulse_triple(wd[t], 4, 0, t);
      MODE_64: begin
        for (int t = 0; t < NUM_TRACKS; t++)
          quad_pulses(((wd[t] << 14) + wd[t + 4]) & 16'hFFFF, t);
      end
      default: ;
    endcase
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin : monitor
    sample_t      want;
    sample_t      got;
    index_words_t w;
    if (!rst_n) begin
      mismatch_count  = 0;
      pending_samples <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        w = {in_ch.pulse_index_7, in_ch.pulse_index_6, in_ch.pulse_index_5,
             in_ch.pulse_index_4, in_ch.pulse_index_3, in_ch.pulse_index_2,
             in_ch.pulse_index_1, in_ch.pulse_index_0};
        build_pulse_vector(in_ch.bit_budget, w);
        for (int k = 0; k < VECTOR_LENGTH; k++) begin
          want.position = POS_W'(k);
          want.value    = VALUE_W'(pulse_sum[k]);
          want.last     = (k == VECTOR_LENGTH - 1);
          expected_samples.push_back(want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.sample_position, out_ch.pulse_value, out_ch.last_sample};
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected sample: pos %0d value %0d last %0b",
                     $realtime, got.position, got.value, got.last);
        end else begin
          want = expected_samples.pop_front();
          if (got.position !== want.position || got.value !== want.value ||
              got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch: exp pos/value/last %0d/%0d/%0b got %0d/%0d/%0b",
                       $realtime, want.position, want.value, want.last,
                       got.position, got.value, got.last);
          end
        end
      end
      pending_samples <= expected_samples.size();
    end
  end

endmodule

/* tb/tb.sv */
// Top of the pulse decoder testbench: clock, reset, subframe stimulus,
// result back-pressure and verdict. Depends on acd_pkg, the channel
// interfaces, the decoder top and pulse_vector_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acd_pkg::*;

  localparam logic [CODE_W-1:0] MODE_LIST [8] = '{MODE_12, MODE_16, MODE_20, MODE_28,
                                                  MODE_36, MODE_44, MODE_52, MODE_64};
  localparam int unsigned ALL_ONES = 16383;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatch_count;
  int   pending_samples;
  int   idle_pct;
  int   stall_pct;
  logic hold_toggle = 1'b0;

  acd_in_if  in_ch ();
  acd_out_if out_ch ();

  algebraic_codebook_pulse_decoder_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pulse_vector_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatch_count),
    .pending_samples (pending_samples)
  );

  always #5 clk = ~clk;

  // Hard stop
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // Result ready: random stalls, plus a long hold-off on request
  initial begin : result_ready
    int   hold_left;
    logic seen_hold;
    hold_left    = 0;
    seen_hold    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != seen_hold) begin
        seen_hold = hold_toggle;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic index_words_t pack_words(
    int unsigned w0, int unsigned w1, int unsigned w2, int unsigned w3,
    int unsigned w4, int unsigned w5, int unsigned w6, int unsigned w7);
    return {WORD_W'(w7), WORD_W'(w6), WORD_W'(w5), WORD_W'(w4),
            WORD_W'(w3), WORD_W'(w2), WORD_W'(w1), WORD_W'(w0)};
  endfunction

  // Offer one subframe until accepted, then maybe idle a few cycles
  task automatic send_subframe(logic [CODE_W-1:0] bits, index_words_t w);
    in_ch.valid         <= 1'b1;
    in_ch.bit_budget    <= bits;
    in_ch.pulse_index_0 <= w[0];
    in_ch.pulse_index_1 <= w[1];
    in_ch.pulse_index_2 <= w[2];
    in_ch.pulse_index_3 <= w[3];
    in_ch.pulse_index_4 <= w[4];
    in_ch.pulse_index_5 <= w[5];
    in_ch.pulse_index_6 <= w[6];
    in_ch.pulse_index_7 <= w[7];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_samples != 0);
  endtask

  // Mostly decodable budgets with random words, some unsupported budgets
  task automatic send_random(int count);
    logic [CODE_W-1:0] bits;
    index_words_t      w;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 8) bits = CODE_W'($urandom_range(0, 127));
      else bits = MODE_LIST[3'($urandom_range(0, 7))];
      for (int i = 0; i < NUM_WORDS; i++)
        w[i] = WORD_W'($urandom_range(0, 16383));
      // sparse words make coincident pulses more likely
      if ($urandom_range(3) == 0)
        for (int i = 0; i < NUM_WORDS; i++)
          w[i] = w[i] & WORD_W'($urandom_range(0, 16383));
      if (bits == MODE_12 && $urandom_range(4) != 0) begin
        w[0] = WORD_W'($urandom_range(0, 1));
        w[2] = WORD_W'($urandom_range(0, 1));
      end
      if (bits == MODE_16 && $urandom_range(1) == 0)
        w[0] = '0;
      send_subframe(bits, w);
    end
  endtask

  initial begin : stimulus
    in_ch.valid         = 1'b0;
    in_ch.bit_budget    = '0;
    in_ch.pulse_index_0 = '0;
    in_ch.pulse_index_1 = '0;
    in_ch.pulse_index_2 = '0;
    in_ch.pulse_index_3 = '0;
    in_ch.pulse_index_4 = '0;
    in_ch.pulse_index_5 = '0;
    in_ch.pulse_index_6 = '0;
    in_ch.pulse_index_7 = '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 12-bit track select, including out-of-range selectors
    send_subframe(MODE_12, '0);
    send_subframe(MODE_12, pack_words(1, 31, 1, ALL_ONES, 0, 0, 0, 0));
    send_subframe(MODE_12, pack_words(ALL_ONES, 5, 9, 20, ALL_ONES, 0, 0, 0));
    // 16-bit: skipped track depends on word 0
    send_subframe(MODE_16, pack_words(0, 31, 16, 15, 0, 0, 0, 0));
    send_subframe(MODE_16, pack_words(ALL_ONES, 0, 31, ALL_ONES, 0, 0, 0, 0));
    send_subframe(MODE_20, '0);
    send_subframe(MODE_20, '1);
    // two-pulse sign rule: below, above, coincident
    send_subframe(MODE_28, pack_words('h053, 'h135, 16, 31, 0, 0, 0, 0));
    send_subframe(MODE_36, pack_words('h077, 'h177, ALL_ONES, 0, 0, 0, 0, 0));
    send_subframe(MODE_44, '0);
    send_subframe(MODE_44, pack_words(0, ALL_ONES, 'h0AA5, 'h1234, 0, 0, 0, 0));
    send_subframe(MODE_52, '1);
    // three coincident pulses of either sign
    send_subframe(MODE_52, pack_words('h0880, 'h18C0, 0, ALL_ONES, 0, 0, 0, 0));
    // 64-bit: each split code, four coincident pulses reach +-4
    send_subframe(MODE_64, pack_words(0, 0, 0, 0, 'h1010, 0, 'h2000, ALL_ONES));
    send_subframe(MODE_64, pack_words(1, 1, 1, 1, ALL_ONES, 0, 'h2AAA, 'h1555));
    send_subframe(MODE_64, pack_words('h3FFE, 2, 2, 2, 'h1555, 'h2AAA, 0,
                                      ALL_ONES));
    send_subframe(MODE_64, pack_words(ALL_ONES, 3, 3, ALL_ONES, 0, ALL_ONES, 'h0F0F,
                                      'h30F0));
    send_subframe(MODE_64, pack_words(0, 1, 2, 3, ALL_ONES, 'h2A55, 'h15AA, 1));
    // unsupported budgets give a zero vector
    send_subframe(7'd0, '1);
    send_subframe(7'd127, '1);
    send_subframe(7'd13, pack_words(5, 31, 7, 9, 1, 2, 3, 4));
    send_subframe(7'd65, {NUM_WORDS{14'h2AAA}});

    // Sender pauses until every sample has come out
    in_ch.valid <= 1'b0;
    wait_drained();

    // Receiver held off while the sender keeps offering; no idling
    hold_toggle <= ~hold_toggle;
    send_random(62);

    idle_pct  = 49;
    stall_pct = 0;
    send_random(62);

    idle_pct  = 0;
    stall_pct = 49;
    send_random(62);

    idle_pct  = 9;
    stall_pct = 9;
    send_random(62);

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_samples == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
